/* design/days_between_dates_assert.svh */
// Assertion macros for the date-difference top level.
`ifndef DAYS_BETWEEN_DATES_ASSERT_SVH
`define DAYS_BETWEEN_DATES_ASSERT_SVH

// Checked at every rising clock edge outside of reset.
`define DBD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked at every rising clock edge, reset included.
`define DBD_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* design/dbd_pkg.sv */
// Shared widths, calendar constants and the month offset table.
package dbd_pkg;

  localparam int DAY_W    = 5;
  localparam int MONTH_W  = 4;
  localparam int YEAR_W   = 14;
  localparam int DN_W     = 22;
  localparam int COUNT_W  = 22;
  localparam int MOFF_W   = 9;

  localparam int MAX_YEAR        = 9999;
  localparam int MONTHS_PER_YEAR = 12;
  localparam int DAYS_PER_YEAR   = 365;

  // Division by 100 as a multiply by a rounded-up reciprocal; exact for values below 43690.
  localparam int DIV100_MUL   = 5243;
  localparam int DIV100_MUL_W = 13;
  localparam int DIV100_SHIFT = 19;
  localparam int PROD_W       = YEAR_W + DIV100_MUL_W;
  localparam int Q_W          = 7;
  localparam int P365_W       = YEAR_W + 9;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  // Days in the year before the first of the given month (1 is January).
  function automatic logic [MOFF_W-1:0] days_before_month(input logic [MONTH_W-1:0] mon);
    logic [MOFF_W-1:0] d;
    unique case (mon)
      4'd1:    d = 9'd0;
      4'd2:    d = 9'd31;
      4'd3:    d = 9'd59;
      4'd4:    d = 9'd90;
      4'd5:    d = 9'd120;
      4'd6:    d = 9'd151;
      4'd7:    d = 9'd181;
      4'd8:    d = 9'd212;
      4'd9:    d = 9'd243;
      4'd10:   d = 9'd273;
      4'd11:   d = 9'd304;
      4'd12:   d = 9'd334;
      default: d = 9'd0;
    endcase
    return d;
  endfunction

endpackage

/* design/dbd_day_num.sv */
// Four-stage pipeline that turns one calendar date into its day number.
module dbd_day_num (
  input  logic                            clk,
  input  logic                            en,
  input  logic [dbd_pkg::DAY_W-1:0]       day,
  input  logic [dbd_pkg::MONTH_W-1:0]     month,
  input  logic [dbd_pkg::YEAR_W-1:0]      year,
  output logic [dbd_pkg::DN_W-1:0]        day_num
);

  // Stage 1 registers: clamped month and year, elapsed years.
  logic [dbd_pkg::DAY_W-1:0]    s1_day;
  logic [dbd_pkg::MONTH_W-1:0]  s1_mon;
  logic [dbd_pkg::YEAR_W-1:0]   s1_yr;
  logic [dbd_pkg::YEAR_W-1:0]   s1_p;

  // Stage 2 registers: reciprocal products and the plain year days.
  logic [dbd_pkg::DAY_W-1:0]    s2_day;
  logic [dbd_pkg::MONTH_W-1:0]  s2_mon;
  logic [dbd_pkg::YEAR_W-1:0]   s2_yr;
  logic [dbd_pkg::YEAR_W-1:0]   s2_p;
  logic [dbd_pkg::PROD_W-1:0]   s2_prod_p;
  logic [dbd_pkg::PROD_W-1:0]   s2_prod_y;
  logic [dbd_pkg::P365_W-1:0]   s2_p365;

  // Stage 3 registers: days before the year and before the month.
  logic [dbd_pkg::DAY_W-1:0]    s3_day;
  logic [dbd_pkg::DN_W-1:0]     s3_year_base;
  logic [dbd_pkg::MOFF_W-1:0]   s3_moff;

  logic [dbd_pkg::MONTH_W-1:0]  mon_clamp;
  logic [dbd_pkg::YEAR_W-1:0]   yr_clamp;
  logic [dbd_pkg::Q_W-1:0]      cent_p;
  logic [dbd_pkg::Q_W-1:0]      cent_y;
  logic [dbd_pkg::YEAR_W-1:0]   cent_y_x100;
  logic                         is_leap;
  logic [dbd_pkg::DN_W-1:0]     year_base;
  logic [dbd_pkg::MOFF_W-1:0]   moff;

  // Out-of-range months and years are pulled to the nearest legal value.
  always_comb begin
    mon_clamp = month;
    if (month == '0) begin
      mon_clamp = dbd_pkg::MONTH_W'(1);
    end else if (month > dbd_pkg::MONTH_W'(dbd_pkg::MONTHS_PER_YEAR)) begin
      mon_clamp = dbd_pkg::MONTH_W'(dbd_pkg::MONTHS_PER_YEAR);
    end
    yr_clamp = year;
    if (year == '0) begin
      yr_clamp = dbd_pkg::YEAR_W'(1);
    end else if (year > dbd_pkg::YEAR_W'(dbd_pkg::MAX_YEAR)) begin
      yr_clamp = dbd_pkg::YEAR_W'(dbd_pkg::MAX_YEAR);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_day <= day;
      s1_mon <= mon_clamp;
      s1_yr  <= yr_clamp;
      s1_p   <= yr_clamp - dbd_pkg::YEAR_W'(1);
    end
  end

  // Multiplies for the century counts of the elapsed years and of the year itself.
  always_ff @(posedge clk) begin
    if (en) begin
      s2_day    <= s1_day;
      s2_mon    <= s1_mon;
      s2_yr     <= s1_yr;
      s2_p      <= s1_p;
      s2_prod_p <= dbd_pkg::PROD_W'(s1_p) * dbd_pkg::PROD_W'(dbd_pkg::DIV100_MUL);
      s2_prod_y <= dbd_pkg::PROD_W'(s1_yr) * dbd_pkg::PROD_W'(dbd_pkg::DIV100_MUL);
      s2_p365   <= dbd_pkg::P365_W'(s1_p) * dbd_pkg::P365_W'(dbd_pkg::DAYS_PER_YEAR);
    end
  end

  // Leap rule, the day count of all whole years before this one and the month offset.
  always_comb begin
    cent_p      = s2_prod_p[dbd_pkg::DIV100_SHIFT +: dbd_pkg::Q_W];
    cent_y      = s2_prod_y[dbd_pkg::DIV100_SHIFT +: dbd_pkg::Q_W];
    cent_y_x100 = dbd_pkg::YEAR_W'(cent_y) * dbd_pkg::YEAR_W'(100);
    is_leap     = (s2_yr[1:0] == 2'b00) &&
                  ((s2_yr != cent_y_x100) || (cent_y[1:0] == 2'b00));
    year_base   = dbd_pkg::DN_W'(s2_p365)
                + dbd_pkg::DN_W'(s2_p >> 2)
                - dbd_pkg::DN_W'(cent_p)
                + dbd_pkg::DN_W'(cent_p >> 2);
    moff        = dbd_pkg::days_before_month(s2_mon)
                + dbd_pkg::MOFF_W'((s2_mon > dbd_pkg::MONTH_W'(2)) && is_leap);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_day       <= s2_day;
      s3_year_base <= year_base;
      s3_moff      <= moff;
    end
  end

  // Final sum of year, month and day parts.
  always_ff @(posedge clk) begin
    if (en) begin
      day_num <= s3_year_base + dbd_pkg::DN_W'(s3_moff) + dbd_pkg::DN_W'(s3_day);
    end
  end

endmodule

/* design/days_between_dates.sv */
// An accepted request moves through the day-number stages, subtract stage and output register.
// Throughput: one request per cycle unless a result is stalled; the two day-number pipelines
// and the subtract stage each take a new date pair every cycle while nothing is stalled.
// A stalled result freezes the whole pipeline in place, so nothing is lost or repeated.
// Synchronous active-high reset clears every stage valid; payload registers are not reset.
`include "days_between_dates_assert.svh"

// Top level: two day-number pipelines, a compare and subtract stage and the output register.
module days_between_dates (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            req_valid,
  output logic                            req_stall,
  input  logic [dbd_pkg::DAY_W-1:0]       start_day,
  input  logic [dbd_pkg::MONTH_W-1:0]     start_month,
  input  logic [dbd_pkg::YEAR_W-1:0]      start_year,
  input  logic [dbd_pkg::DAY_W-1:0]       end_day,
  input  logic [dbd_pkg::MONTH_W-1:0]     end_month,
  input  logic [dbd_pkg::YEAR_W-1:0]      end_year,
  input  logic                            include_end_day,
  output logic                            res_valid,
  input  logic                            res_stall,
  output logic [dbd_pkg::COUNT_W-1:0]     day_count
);

  localparam int NUM_STAGES = 5;

  logic                          en;
  logic [NUM_STAGES-1:0]         vld;
  logic [NUM_STAGES-2:0]         flag;
  logic [dbd_pkg::DN_W-1:0]      start_num;
  logic [dbd_pkg::DN_W-1:0]      end_num;
  logic [dbd_pkg::DN_W-1:0]      diff;
  logic                          diff_flag;
  logic [dbd_pkg::COUNT_W:0]     count_sum;

  // The pipeline moves unless a finished result is held by the receiver.
  assign en        = !(res_valid && res_stall);
  assign req_stall = !en;

  dbd_day_num u_start_num (
    .clk     (clk),
    .en      (en),
    .day     (start_day),
    .month   (start_month),
    .year    (start_year),
    .day_num (start_num)
  );

  dbd_day_num u_end_num (
    .clk     (clk),
    .en      (en),
    .day     (end_day),
    .month   (end_month),
    .year    (end_year),
    .day_num (end_num)
  );

  // Valid bits travel alongside the day-number stages.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[NUM_STAGES-2:0], req_valid};
    end
  end

  // The include flag follows its request down the pipeline.
  always_ff @(posedge clk) begin
    if (en) begin
      flag <= {flag[NUM_STAGES-3:0], include_end_day};
    end
  end

  // Difference of day numbers, zero when the start is not earlier.
  always_ff @(posedge clk) begin
    if (en) begin
      diff      <= (start_num < end_num) ? (end_num - start_num) : '0;
      diff_flag <= flag[NUM_STAGES-2];
    end
  end

  assign count_sum = {1'b0, diff} + (dbd_pkg::COUNT_W + 1)'(diff_flag);

  // Output register: add one for the end day when it is included, and saturate.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (en) begin
      res_valid <= vld[NUM_STAGES-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      day_count <= count_sum[dbd_pkg::COUNT_W] ? dbd_pkg::COUNT_MAX
                                                : count_sum[dbd_pkg::COUNT_W-1:0];
    end
  end

  // An accepted request always enters the first stage.
  `DBD_ASSERT(a_req_enters, req_valid && !req_stall |=> vld[0], "accepted request was dropped")
  // A taken result with an empty stage behind it leaves the output empty.
  `DBD_ASSERT(a_no_invent, res_valid && !res_stall && !vld[NUM_STAGES-1] |=> !res_valid,
              "result appeared without a request")
  // A held result keeps the stages behind it frozen.
  `DBD_ASSERT(a_freeze, res_valid && res_stall |=> $stable(vld) && $stable(diff),
              "pipeline moved under a stalled result")
  // Reset empties the output and every stage valid.
  `DBD_ASSERT_ALWAYS(a_reset_clears, rst |=> !res_valid && vld == '0,
                     "valid bits survived reset")

endmodule
